>>> hdl/bsse_pkg.sv
// Shared types, constants and helper functions for the B-spline surface evaluator.
`default_nettype none
package bsse_pkg;
  localparam int MaxDegree = 3;
  localparam int MaxPoints = 16;
  localparam int MaxKnots  = 20;
  localparam int CpDepth   = 256;
  localparam int KIdxW     = 5;

  typedef enum logic [1:0] {
    REQ_CP    = 2'd0,
    REQ_UKNOT = 2'd1,
    REQ_VKNOT = 2'd2,
    REQ_EVAL  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_U_DEGREE = 2'd0,
    CFG_V_DEGREE = 2'd1,
    CFG_U_COUNT  = 2'd2,
    CFG_V_COUNT  = 2'd3
  } cfg_idx_t;

  // One queued request handed from the front end to the evaluator.
  typedef struct packed {
    logic        is_eval;
    logic        range_ok;
    logic [16:0] pu;
    logic [16:0] pv;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_USPAN, ST_UBAS, ST_VSPAN, ST_VBAS, ST_WT, ST_RD, ST_ACC, ST_DONE
  } st_t;

  function automatic logic [1:0] eff_deg(input logic [1:0] d);
    eff_deg = (d == 2'd0) ? 2'd1 : d;
  endfunction

  function automatic logic [4:0] eff_cnt(input logic [4:0] c, input logic [1:0] d);
    logic [5:0] v;
    v = {1'b0, c};
    if (v < 6'd2) v = 6'd2;
    if (v > 6'(MaxPoints)) v = 6'(MaxPoints);
    if (v < 6'(d) + 6'd1) v = 6'(d) + 6'd1;
    if (v + 6'(d) + 6'd1 > 6'(MaxKnots)) v = 6'(MaxKnots) - 6'(d) - 6'd1;
    eff_cnt = v[4:0];
  endfunction
endpackage
`default_nettype wire

>>> hdl/bsse_if.sv
// Valid/ready channel interfaces for the evaluator.
`default_nettype none
interface bsse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  entry_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [16:0] knot_value;
  logic [16:0] param_u;
  logic [16:0] param_v;
  modport source(output valid, req_type, entry_index, coord_x, coord_y, coord_z,
                 knot_value, param_u, param_v, input ready);
  modport sink(input valid, req_type, entry_index, coord_x, coord_y, coord_z,
               knot_value, param_u, param_v, output ready);
endinterface

interface bsse_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        in_range;
  modport source(output valid, point_x, point_y, point_z, in_range, input ready);
  modport sink(input valid, point_x, point_y, point_z, in_range, output ready);
endinterface

interface bsse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [4:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/bsse_front.sv
// Front end: forwards loads to the store write ports and queues evaluate jobs for the back end.
`default_nettype none
module bsse_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bsse_in_if.sink              in_ch,
  output bsse_pkg::job_t       job,
  output logic                 job_valid,
  input  wire logic            job_pop,
  // control point write port
  output logic                 cp_we,
  output logic [7:0]           cp_waddr,
  output logic [95:0]          cp_wdata,
  // knot write port
  output logic                 uk_we,
  output logic                 vk_we,
  output logic [4:0]           k_waddr,
  output logic [16:0]          k_wdata
);
  import bsse_pkg::*;
  job_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       acc;

  // A load waits until no evaluate is queued or running, so it cannot change an earlier result.
  assign in_ch.ready = (in_ch.req_type == REQ_EVAL) ? (cnt_r != 2'd2) : (cnt_r == 2'd0);
  assign acc = in_ch.valid && in_ch.ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];

  assign cp_we    = acc && (in_ch.req_type == REQ_CP);
  assign cp_waddr = in_ch.entry_index;
  assign cp_wdata = {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
  assign k_waddr  = in_ch.entry_index[4:0];
  assign k_wdata  = (in_ch.knot_value > 17'd65536) ? 17'd65536 : in_ch.knot_value;
  assign uk_we = acc && (in_ch.req_type == REQ_UKNOT) && (in_ch.entry_index < 8'(MaxKnots));
  assign vk_we = acc && (in_ch.req_type == REQ_VKNOT) && (in_ch.entry_index < 8'(MaxKnots));

  logic push;
  assign push = acc && (in_ch.req_type == REQ_EVAL);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
    end
    if (push) begin
      q_r[wp_r].is_eval  <= 1'b1;
      q_r[wp_r].range_ok <= (in_ch.param_u <= 17'd65536) && (in_ch.param_v <= 17'd65536);
      q_r[wp_r].pu       <= in_ch.param_u;
      q_r[wp_r].pv       <= in_ch.param_v;
    end
  end
endmodule
`default_nettype wire

>>> hdl/bsse_back.sv
// Back end: span search, basis recursion and weighted control point sum.
`default_nettype none
module bsse_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bsse_pkg::job_t  job,
  input  wire logic            job_valid,
  output logic                 job_pop,
  input  wire logic [1:0]      du,
  input  wire logic [1:0]      dv,
  input  wire logic [4:0]      cu,
  input  wire logic [4:0]      cv,
  input  wire logic            cp_we,
  input  wire logic [7:0]      cp_waddr,
  input  wire logic [95:0]     cp_wdata,
  input  wire logic            uk_we,
  input  wire logic            vk_we,
  input  wire logic [4:0]      k_waddr,
  input  wire logic [16:0]     k_wdata,
  bsse_out_if.source           out_ch
);
  import bsse_pkg::*;

  logic [95:0] cp_mem [CpDepth];
  logic [16:0] uk_r [MaxKnots];
  logic [16:0] vk_r [MaxKnots];
  logic [95:0] cp_rd_r;

  st_t st_r, st_nxt;
  logic        dir_r;            // 0 = u, 1 = v
  logic [4:0]  k_r;              // span search index
  logic [4:0]  span_r;
  logic [1:0]  j_r, r_r;
  logic [1:0]  ph_r;             // basis term phase
  logic [1:0]  a_r, b_r;
  logic [1:0]  c_r;
  logic signed [33:0] nu_r [MaxDegree+1];
  logic signed [33:0] nv_r [MaxDegree+1];
  logic signed [33:0] prev_r;
  logic signed [67:0] carry_r;
  logic signed [33:0] wt_r;
  logic signed [63:0] acc_r [3];
  logic [7:0]  pi_r;
  logic [4:0]  su_r;

  // Shared multiply / divide unit.
  logic signed [67:0] prod_r;
  logic [67:0] quo_r, rem_r;
  logic [17:0] den_r;
  logic [6:0]  dcnt_r;
  logic        dneg_r, dbusy_r, dstart;
  logic signed [67:0] mul_res;

  logic [1:0]  deg;
  logic [4:0]  cnt;
  logic [16:0] t;
  assign deg = dir_r ? dv : du;
  assign cnt = dir_r ? cv : cu;
  assign t   = dir_r ? job.pv : job.pu;

  function automatic logic [16:0] kat(input logic d, input logic [5:0] i,
                                      input logic [16:0] a [MaxKnots],
                                      input logic [16:0] b [MaxKnots]);
    if (i >= 6'(MaxKnots)) kat = 17'd0;
    else kat = d ? b[i[4:0]] : a[i[4:0]];
  endfunction

  logic [16:0] kk, kk1, hi, lo;
  assign kk  = kat(dir_r, {1'b0, k_r}, uk_r, vk_r);
  assign kk1 = kat(dir_r, {1'b0, k_r} + 6'd1, uk_r, vk_r);
  assign hi  = kat(dir_r, {1'b0, span_r} + {4'd0, r_r} + 6'd1, uk_r, vk_r);
  assign lo  = kat(dir_r, {1'b0, span_r} + 6'd1 - {4'd0, j_r} + {4'd0, r_r}, uk_r, vk_r);

  logic signed [33:0] prev;
  assign prev = dir_r ? nv_r[r_r] : nu_r[r_r];

  function automatic logic signed [33:0] sat(input logic signed [67:0] v,
                                             input logic signed [67:0] lim);
    if (v > lim) sat = lim[33:0];
    else if (v < -lim) sat = 34'(-lim);
    else sat = v[33:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  localparam logic signed [67:0] BLim = 68'sd2147483648;
  localparam logic signed [67:0] WLim = 68'sd4294967295;
  localparam logic signed [67:0] One  = 68'sd1073741824;

  logic signed [67:0] qs;
  assign qs = dneg_r ? -$signed(quo_r) : $signed(quo_r);

  logic signed [33:0] sum_term;
  assign sum_term = sat(carry_r + qs, BLim);

  // Product divided by 2^30, truncated toward zero.
  logic signed [67:0] q30;
  assign q30 = (prod_r + (prod_r[67] ? 68'sd1073741823 : 68'sd0)) >>> 30;

  logic signed [31:0] cpc;
  always_comb begin
    case (c_r)
      2'd0: cpc = $signed(cp_rd_r[31:0]);
      2'd1: cpc = $signed(cp_rd_r[63:32]);
      default: cpc = $signed(cp_rd_r[95:64]);
    endcase
  end

  // Multiplier operands selected per state.
  logic signed [33:0] ma, mb;
  always_comb begin
    ma = (ph_r == 2'd2) ? prev_r : prev;
    mb = (ph_r == 2'd0) ? $signed({17'd0, hi}) - $signed({17'd0, t})
                        : $signed({17'd0, t}) - $signed({17'd0, lo});
    if (st_r == ST_WT) begin
      ma = nu_r[a_r];
      mb = nv_r[b_r];
    end else if (st_r == ST_ACC) begin
      ma = 34'(cpc);
      mb = wt_r;
    end
  end
  assign mul_res = 68'(ma) * 68'(mb);

  always_ff @(posedge clk) begin
    if (cp_we) cp_mem[cp_waddr] <= cp_wdata;
    cp_rd_r <= cp_mem[pi_r];
    if (uk_we) uk_r[k_waddr] <= k_wdata;
    if (vk_we) vk_r[k_waddr] <= k_wdata;
  end

  // Restoring divider, one quotient bit a cycle over 68 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (dstart) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= 7'd68;
      quo_r   <= prod_r[67] ? 68'(-prod_r) : 68'(prod_r);
      dneg_r  <= prod_r[67] ^ den_r[17];
      rem_r   <= 68'd0;
    end else if (dbusy_r) begin
      if (dcnt_r == 7'd0) begin
        dbusy_r <= 1'b0;
      end else begin
        logic [68:0] tr;
        tr = {rem_r, quo_r[67]} - {51'd0, (den_r[17] ? 18'(-den_r) : den_r)};
        if (!tr[68]) begin
          rem_r <= tr[67:0];
          quo_r <= {quo_r[66:0], 1'b1};
        end else begin
          rem_r <= {rem_r[66:0], quo_r[67]};
          quo_r <= {quo_r[66:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 7'd1;
      end
    end
  end

  // The quotient is final in the cycle after the last step.
  logic ddone;
  assign ddone = dbusy_r && (dcnt_r == 7'd0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (job_valid) st_nxt = job.range_ok ? ST_USPAN : ST_DONE;
      ST_USPAN: if (k_r >= cnt - 5'd1) st_nxt = ST_UBAS;
      ST_UBAS:  if (ph_r == 2'd3 && j_r == deg && r_r == j_r - 2'd1
                    && (ddone || den_r == 18'd0))
                  st_nxt = ST_VSPAN;
      ST_VSPAN: if (k_r >= cnt - 5'd1) st_nxt = ST_VBAS;
      ST_VBAS:  if (ph_r == 2'd3 && j_r == deg && r_r == j_r - 2'd1
                    && (ddone || den_r == 18'd0))
                  st_nxt = ST_WT;
      ST_WT:    if (ph_r == 2'd1) st_nxt = ST_RD;
      ST_RD:    if (ph_r == 2'd1) st_nxt = ST_ACC;
      ST_ACC:   if (ph_r == 2'd1 && c_r == 2'd2)
                  st_nxt = (a_r == du && b_r == dv) ? ST_DONE : ST_WT;
      ST_DONE:  if (out_ch.ready || !out_ch.valid) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dstart  = 1'b0;
    job_pop = (st_r == ST_DONE) && (st_nxt == ST_IDLE);
    case (st_r)
      ST_UBAS, ST_VBAS: dstart = (ph_r == 2'd1 || ph_r == 2'd3) && !dbusy_r && den_r != 18'd0
                                 && !ddone;
      default:          dstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && st_nxt == ST_IDLE) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        dir_r <= 1'b0; k_r <= {3'd0, du}; span_r <= {3'd0, du};
        acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
        j_r <= 2'd1; r_r <= 2'd0; ph_r <= 2'd0; carry_r <= '0;
        a_r <= 2'd0; b_r <= 2'd0; c_r <= 2'd0;
        nu_r[0] <= 34'(One);
        nv_r[0] <= 34'(One);
      end
      ST_USPAN, ST_VSPAN: begin
        if ({1'b0, kk} <= {1'b0, t} && kk < kk1 && k_r <= cnt - 5'd1) span_r <= k_r;
        k_r <= k_r + 5'd1;
        if (st_nxt != st_r) begin
          j_r <= 2'd1; r_r <= 2'd0; ph_r <= 2'd0; carry_r <= '0;
        end
      end
      ST_UBAS, ST_VBAS: begin
        // Phases: 0 mult hi-t, 1 divide, 2 mult t-lo, 3 divide.
        case (ph_r)
          2'd0, 2'd2: begin
            prod_r <= mul_res;
            den_r  <= {1'b0, hi} - {1'b0, lo};
            ph_r   <= ph_r + 2'd1;
            if (ph_r == 2'd0) prev_r <= prev;
          end
          default: begin
            if (den_r == 18'd0 || ddone) begin
              if (ph_r == 2'd1) begin
                if (dir_r) nv_r[r_r] <= (den_r == 18'd0) ? sat(carry_r, BLim) : sum_term;
                else       nu_r[r_r] <= (den_r == 18'd0) ? sat(carry_r, BLim) : sum_term;
                ph_r <= 2'd2;
              end else begin
                logic signed [67:0] cn;
                cn = (den_r == 18'd0) ? 68'sd0 : qs;
                ph_r <= 2'd0;
                if (r_r == j_r - 2'd1) begin
                  if (dir_r) nv_r[j_r] <= sat(cn, BLim);
                  else       nu_r[j_r] <= sat(cn, BLim);
                  carry_r <= '0; r_r <= 2'd0; j_r <= j_r + 2'd1;
                  if (j_r == deg) begin
                    if (!dir_r) begin
                      su_r <= span_r; dir_r <= 1'b1;
                      k_r <= {3'd0, dv}; span_r <= {3'd0, dv};
                    end
                  end
                end else begin
                  carry_r <= cn; r_r <= r_r + 2'd1;
                end
              end
            end
          end
        endcase
      end
      ST_WT: begin
        case (ph_r)
          2'd0: begin
            prod_r <= mul_res; ph_r <= 2'd1;
          end
          default: begin
            wt_r <= sat(q30, WLim);
            ph_r <= 2'd0;
            pi_r <= 8'((({3'd0, su_r} - {6'd0, du} + {6'd0, a_r}) * {3'd0, cv})
                     + ({3'd0, span_r} - {6'd0, dv} + {6'd0, b_r}));
          end
        endcase
      end
      ST_RD: begin
        ph_r <= (ph_r == 2'd1) ? 2'd0 : 2'd1;
        c_r <= 2'd0;
      end
      ST_ACC: begin
        case (ph_r)
          2'd0: begin
            prod_r <= mul_res; ph_r <= 2'd1;
          end
          default: begin
            acc_r[c_r] <= acc_r[c_r] + q30[63:0];
            ph_r <= 2'd0;
            if (c_r == 2'd2) begin
              c_r <= 2'd0;
              if (b_r == dv) begin b_r <= 2'd0; a_r <= a_r + 2'd1; end
              else b_r <= b_r + 2'd1;
            end else c_r <= c_r + 2'd1;
          end
        endcase
      end
      ST_DONE: begin
        if (st_nxt == ST_IDLE) begin
          out_ch.in_range <= job.range_ok;
          out_ch.point_x  <= job.range_ok ? sat32(acc_r[0]) : 32'sd0;
          out_ch.point_y  <= job.range_ok ? sat32(acc_r[1]) : 32'sd0;
          out_ch.point_z  <= job.range_ok ? sat32(acc_r[2]) : 32'sd0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/bspline_surface_point_eval_top.sv
// Top level of the B-spline surface point evaluator.
//  channel | dir | payload
//  in_     | in  | req_type, entry_index, coord_x/y/z, knot_value, param_u/v
//  out_    | out | point_x/y/z, in_range
//  cfg_    | in  | index (2 bits), data (5 bits)
// Loads wait while an evaluate is queued or in flight.
// An evaluate spends most of its time in the bit-serial divider, which serves the 12 basis
// term divisions per axis at degree 3; the weight and sum for each control point use
// the multiplier and shifts instead.
// Reset is synchronous and clears control only; stores are undefined until written.
// A two-entry job queue lets new evaluates enter while the back end works.
`default_nettype none
module bspline_surface_point_eval_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsse_in_if.sink    in_ch,
  bsse_out_if.source out_ch,
  bsse_cfg_if.sink   cfg_ch
);
  import bsse_pkg::*;
  logic [1:0] ud_r, vd_r;
  logic [4:0] uc_r, vc_r;
  job_t job;
  logic job_valid, job_pop, cp_we, uk_we, vk_we;
  logic [7:0] cp_waddr;
  logic [95:0] cp_wdata;
  logic [4:0] k_waddr;
  logic [16:0] k_wdata;
  logic [1:0] du, dv;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ud_r <= 2'd3; vd_r <= 2'd3; uc_r <= 5'd4; vc_r <= 5'd4;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_U_DEGREE: ud_r <= cfg_ch.data[1:0];
        CFG_V_DEGREE: vd_r <= cfg_ch.data[1:0];
        CFG_U_COUNT:  uc_r <= cfg_ch.data;
        CFG_V_COUNT:  vc_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign du = eff_deg(ud_r);
  assign dv = eff_deg(vd_r);

  bsse_front u_front (.clk, .rst_n, .in_ch, .job, .job_valid, .job_pop,
    .cp_we, .cp_waddr, .cp_wdata, .uk_we, .vk_we, .k_waddr, .k_wdata);
  bsse_back u_back (.clk, .rst_n, .job, .job_valid, .job_pop, .du, .dv,
    .cu(eff_cnt(uc_r, du)), .cv(eff_cnt(vc_r, dv)),
    .cp_we, .cp_waddr, .cp_wdata, .uk_we, .vk_we, .k_waddr, .k_wdata, .out_ch);
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the B-spline surface point evaluator top level.
`timescale 1ns / 100ps
module testbench;
  import bsse_pkg::*;

  localparam longint OneQ30   = 64'sd1 << 30;
  localparam longint BasisLim = 64'sd1 << 31;
  localparam longint WeightLim = (64'sd1 << 32) - 1;
  localparam longint CycleLimit = 64'd60_000_000;
  localparam int     PhaseItems = 160;

  typedef struct {
    req_t        kind;
    logic [7:0]  idx;
    logic [31:0] x, y, z;
    logic [16:0] kv, pu, pv;
  } req_item_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        in_range;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bsse_in_if  in_ch ();
  bsse_out_if out_ch ();
  bsse_cfg_if cfg_ch ();

  bspline_surface_point_eval_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  req_item_t pending_reqs[$];
  point_t    expected_points[$];
  int        errors = 0;
  longint    cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      in_took = 1'b0;

  // Shadow of the block's stores and registers, updated on accepted transactions.
  logic [31:0] cp_mem[CpDepth][3];
  logic [16:0] uk_mem[MaxKnots];
  logic [16:0] vk_mem[MaxKnots];
  logic [1:0]  reg_udeg = 2'd3, reg_vdeg = 2'd3;
  logic [4:0]  reg_ucnt = 5'd4, reg_vcnt = 5'd4;

  // Knots as the stimulus generator believes they will be, ahead of acceptance.
  logic [16:0] plan_uk[MaxKnots];
  logic [16:0] plan_vk[MaxKnots];

  function automatic int degree_of(logic [1:0] d);
    return (d == 2'd0) ? 1 : int'(d);
  endfunction

  function automatic int count_of(logic [4:0] c, int deg);
    int v;
    v = int'(c);
    if (v < 2) v = 2;
    if (v > MaxPoints) v = MaxPoints;
    if (v < deg + 1) v = deg + 1;
    if (v + deg + 1 > MaxKnots) v = MaxKnots - deg - 1;
    return v;
  endfunction

  function automatic longint knot_val(bit v_dir, int idx);
    if (idx < 0 || idx >= MaxKnots) return 0;
    return v_dir ? longint'(vk_mem[idx]) : longint'(uk_mem[idx]);
  endfunction

  function automatic longint limit_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint cdb_term(longint num, longint b, longint den);
    if (den == 0) return 0;
    return (num * b) / den;
  endfunction

  task automatic span_basis(input bit v_dir, input int deg, input int cnt, input longint t,
                            output int span, output longint nb[4]);
    longint carry, hi, lo, den, prev;
    span = deg;
    for (int k = deg; k <= cnt - 1; k++)
      if (knot_val(v_dir, k) <= t && knot_val(v_dir, k) < knot_val(v_dir, k + 1)) span = k;
    nb[0] = OneQ30;
    for (int j = 1; j <= deg; j++) begin
      carry = 0;
      for (int r = 0; r < j; r++) begin
        hi = knot_val(v_dir, span + r + 1);
        lo = knot_val(v_dir, span + 1 - j + r);
        den = hi - lo;
        prev = nb[r];
        nb[r] = limit_to(carry + cdb_term(hi - t, prev, den), BasisLim);
        carry = cdb_term(t - lo, prev, den);
      end
      nb[j] = limit_to(carry, BasisLim);
    end
  endtask

  task automatic predict_point(input logic [16:0] pu, input logic [16:0] pv);
    point_t p;
    int du, dv, cu, cv, su, sv, idx;
    longint nu[4], nv[4], acc[3], w;
    p = '{32'd0, 32'd0, 32'd0, 1'b0};
    if (pu > 17'd65536 || pv > 17'd65536) begin
      expected_points.push_back(p);
      return;
    end
    du = degree_of(reg_udeg);
    dv = degree_of(reg_vdeg);
    cu = count_of(reg_ucnt, du);
    cv = count_of(reg_vcnt, dv);
    span_basis(1'b0, du, cu, longint'(pu), su, nu);
    span_basis(1'b1, dv, cv, longint'(pv), sv, nv);
    acc = '{0, 0, 0};
    for (int a = 0; a <= du; a++)
      for (int b = 0; b <= dv; b++) begin
        idx = ((su - du + a) * cv + (sv - dv + b)) & (CpDepth - 1);
        w = limit_to((nu[a] * nv[b]) / OneQ30, WeightLim);
        for (int c = 0; c < 3; c++)
          acc[c] += (longint'(signed'(cp_mem[idx][c])) * w) / OneQ30;
      end
    for (int c = 0; c < 3; c++) begin
      if (acc[c] > 64'sd2147483647) acc[c] = 64'sd2147483647;
      if (acc[c] < -64'sd2147483648) acc[c] = -64'sd2147483648;
    end
    p.x = acc[0][31:0];
    p.y = acc[1][31:0];
    p.z = acc[2][31:0];
    p.in_range = 1'b1;
    expected_points.push_back(p);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  // Input transaction acceptance: update the shadow stores or predict a point.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL bspline_surface_point_eval_top");
      $finish;
    end
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (req_t'(in_ch.req_type))
        REQ_CP: begin
          cp_mem[in_ch.entry_index][0] = in_ch.coord_x;
          cp_mem[in_ch.entry_index][1] = in_ch.coord_y;
          cp_mem[in_ch.entry_index][2] = in_ch.coord_z;
        end
        REQ_UKNOT, REQ_VKNOT: begin
          if (in_ch.entry_index < MaxKnots) begin
            if (req_t'(in_ch.req_type) == REQ_UKNOT)
              uk_mem[in_ch.entry_index] = (in_ch.knot_value > 17'd65536) ? 17'd65536
                                                                          : in_ch.knot_value;
            else
              vk_mem[in_ch.entry_index] = (in_ch.knot_value > 17'd65536) ? 17'd65536
                                                                          : in_ch.knot_value;
          end
        end
        default: predict_point(in_ch.param_u, in_ch.param_v);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        report("unexpected result x", out_ch.point_x, 0);
      end else begin
        e = expected_points.pop_front();
        if (out_ch.point_x !== e.x) report("point_x", out_ch.point_x, e.x);
        if (out_ch.point_y !== e.y) report("point_y", out_ch.point_y, e.y);
        if (out_ch.point_z !== e.z) report("point_z", out_ch.point_z, e.z);
        if (out_ch.in_range !== e.in_range) report("in_range", out_ch.in_range, e.in_range);
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    req_item_t it;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_reqs.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= it.kind;
        in_ch.entry_index <= it.idx;
        in_ch.coord_x     <= it.x;
        in_ch.coord_y     <= it.y;
        in_ch.coord_z     <= it.z;
        in_ch.knot_value  <= it.kv;
        in_ch.param_u     <= it.pu;
        in_ch.param_v     <= it.pv;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic req_item_t noise_item(req_t kind);
    req_item_t it;
    it.kind = kind;
    it.idx = 8'($urandom);
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.kv = 17'($urandom);
    it.pu = 17'($urandom);
    it.pv = 17'($urandom);
    return it;
  endfunction

  task automatic send_point(input logic [7:0] idx, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    req_item_t it;
    it = noise_item(REQ_CP);
    it.idx = idx;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_reqs.push_back(it);
  endtask

  task automatic send_knot(input bit v_dir, input logic [7:0] idx, input logic [16:0] val);
    req_item_t it;
    it = noise_item(v_dir ? REQ_VKNOT : REQ_UKNOT);
    it.idx = idx;
    it.kv = val;
    pending_reqs.push_back(it);
    if (idx < MaxKnots) begin
      if (v_dir) plan_vk[idx] = (val > 17'd65536) ? 17'd65536 : val;
      else plan_uk[idx] = (val > 17'd65536) ? 17'd65536 : val;
    end
  endtask

  task automatic send_eval(input logic [16:0] pu, input logic [16:0] pv);
    req_item_t it;
    it = noise_item(REQ_EVAL);
    it.pu = pu;
    it.pv = pv;
    pending_reqs.push_back(it);
  endtask

  task automatic wait_quiet();
    wait (pending_reqs.size() == 0 && !in_ch.valid && expected_points.size() == 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [4:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_U_DEGREE: reg_udeg = val[1:0];
      CFG_V_DEGREE: reg_vdeg = val[1:0];
      CFG_U_COUNT:  reg_ucnt = val;
      default:      reg_vcnt = val;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Rewrites a whole knot vector, always sorted and mostly clamped, sometimes with repeats.
  task automatic load_knot_vector(input bit v_dir);
    logic [16:0] q[$];
    int style, deg, n;
    style = $urandom_range(3);
    deg = degree_of(v_dir ? reg_vdeg : reg_udeg);
    n = count_of(v_dir ? reg_vcnt : reg_ucnt, deg) + deg + 1;
    for (int i = 0; i < MaxKnots; i++)
      q.push_back(style == 1 ? 17'($urandom_range(8) * 8192) : 17'($urandom_range(65536)));
    q.sort();
    if (style != 2) begin
      for (int i = 0; i <= deg; i++) q[i] = 17'd0;
      for (int i = n - deg - 1; i < MaxKnots; i++) q[i] = 17'd65536;
    end
    for (int i = 0; i < MaxKnots; i++) send_knot(v_dir, 8'(i), q[i]);
  endtask

  function automatic logic [31:0] coord_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 2 * 65536)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] param_value(bit v_dir);
    case ($urandom_range(9))
      0, 1, 2: return v_dir ? plan_vk[$urandom_range(MaxKnots - 1)]
                            : plan_uk[$urandom_range(MaxKnots - 1)];
      3: return 17'd65536;
      4: return 17'd0;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_item();
    int pick, i;
    bit v_dir;
    logic [16:0] lo, hi;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_eval(17'($urandom_range(65537, 131071)), param_value(1));
        else send_eval(param_value(0), 17'($urandom_range(65537, 131071)));
      end else begin
        send_eval(param_value(0), param_value(1));
      end
    end else if (pick < 70) begin
      send_point(8'($urandom), coord_value(), coord_value(), coord_value());
    end else if (pick < 92) begin
      // Knot update that keeps the vector sorted.
      v_dir = $urandom_range(1);
      i = $urandom_range(MaxKnots - 1);
      lo = (i > 0) ? (v_dir ? plan_vk[i - 1] : plan_uk[i - 1]) : 17'd0;
      hi = (i < MaxKnots - 1) ? (v_dir ? plan_vk[i + 1] : plan_uk[i + 1]) : 17'd65536;
      if (hi < lo) hi = lo;
      send_knot(v_dir, 8'(i), 17'($urandom_range(lo, hi)));
    end else begin
      send_knot($urandom_range(1), 8'($urandom), 17'($urandom));
    end
  endtask

  initial begin
    logic [4:0] settings[6][4];
    settings = '{'{5'd3, 5'd3, 5'd4, 5'd4}, '{5'd1, 5'd1, 5'd2, 5'd2},
                 '{5'd3, 5'd3, 5'd16, 5'd16}, '{5'd2, 5'd1, 5'd9, 5'd5},
                 '{5'd0, 5'd0, 5'd0, 5'd31}, '{5'd3, 5'd2, 5'd31, 5'd1}};
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CP;
    in_ch.entry_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.knot_value = '0;
    in_ch.param_u = '0;
    in_ch.param_v = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_U_DEGREE;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p % 3 == 0) ? 19 : (p % 3 == 1) ? 64 : 0;
      recv_idle_pct = (p % 3 == 0) ? 64 : (p % 3 == 1) ? 19 : 0;
      write_reg(CFG_U_DEGREE, settings[p][0]);
      write_reg(CFG_V_DEGREE, settings[p][1]);
      write_reg(CFG_U_COUNT, settings[p][2]);
      write_reg(CFG_V_COUNT, settings[p][3]);
      if (p == 0)
        for (int i = 0; i < CpDepth; i++)
          send_point(8'(i), coord_value(), coord_value(), coord_value());
      load_knot_vector(1'b0);
      load_knot_vector(1'b1);
      if (p == 0) begin
        send_eval(17'd0, 17'd0);
        send_eval(17'd65536, 17'd65536);
        send_eval(17'd32768, 17'd0);
        send_eval(17'd65537, 17'd0);
        send_eval(17'd0, 17'd131071);
        send_eval(17'd131071, 17'd131071);
        send_knot(1'b0, 8'd20, 17'd5);
        send_knot(1'b1, 8'd255, 17'd131071);
        send_eval(17'd40000, 17'd20000);
        for (int i = 0; i < 16; i++)
          send_point(8'(i), 32'h7fff_ffff, 32'h8000_0000, (i % 2) ? 32'h7fff_ffff : 32'h0);
        send_point(8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h1_0000);
        send_eval(17'd16384, 17'd49152);
        send_eval(17'd65536, 17'd0);
        // Unsorted knots drive the basis far outside [0,1].
        send_knot(1'b0, 8'd4, 17'd0);
        send_knot(1'b0, 8'd3, 17'd65536);
        send_eval(17'd30000, 17'd30000);
        load_knot_vector(1'b0);
      end
      for (int i = 0; i < PhaseItems; i++) begin
        random_item();
        if (p == 2 && i == PhaseItems / 2) wait_quiet();
      end
      wait_quiet();
      repeat (100) @(posedge clk);
    end

    if (errors == 0) $display("PASS bspline_surface_point_eval_top");
    else $display("FAIL bspline_surface_point_eval_top");
    $finish;
  end
endmodule
